/* hw/rtl/rlhs_pkg.sv */
// ----------------------------------------------------------------------------
// rlhs_pkg
// Shared types and constants of the rate limited height smoother.
// ----------------------------------------------------------------------------
package rlhs_pkg;

  localparam int unsigned CFG_W     = 12;
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned H_W       = 16;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;

  // floor(x / 20) == (x * DIV20_MUL) >> DIV20_SHIFT for any 16-bit x
  localparam int unsigned DIV20_SHIFT = 21;
  localparam logic [16:0] DIV20_MUL   = 17'd104858;

  // register index, taken from paddr[4:2]
  localparam logic [2:0] REG_MAX_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_FALL_LIMIT  = 3'd1;
  localparam logic [2:0] REG_RISE_LIMIT  = 3'd2;
  localparam logic [2:0] REG_JUMP_LIMIT  = 3'd3;
  localparam logic [2:0] REG_JUMP_VALUE  = 3'd4;
  localparam logic [2:0] REG_BLEND_FLOOR = 3'd5;
  localparam logic [2:0] REG_BLEND_STEP  = 3'd6;

  localparam logic [CFG_W-1:0] RST_MAX_HEIGHT  = 12'd2500;
  localparam logic [CFG_W-1:0] RST_FALL_LIMIT  = 12'd400;
  localparam logic [CFG_W-1:0] RST_RISE_LIMIT  = 12'd400;
  localparam logic [CFG_W-1:0] RST_JUMP_LIMIT  = 12'd600;
  localparam logic [CFG_W-1:0] RST_JUMP_VALUE  = 12'd3000;
  localparam logic [CFG_W-1:0] RST_BLEND_FLOOR = 12'd600;
  localparam logic [CFG_W-1:0] RST_BLEND_STEP  = 12'd40;

  typedef enum logic [2:0] {
    OUT_OK    = 3'd0,
    OUT_RANGE = 3'd1,
    OUT_FALL  = 3'd2,
    OUT_RISE  = 3'd3,
    OUT_JUMP  = 3'd4
  } outcome_e;

  typedef struct packed {
    logic [CFG_W-1:0] max_height;
    logic [CFG_W-1:0] fall_limit;
    logic [CFG_W-1:0] rise_limit;
    logic [CFG_W-1:0] jump_limit;
    logic [CFG_W-1:0] jump_value;
    logic [CFG_W-1:0] blend_floor;
    logic [CFG_W-1:0] blend_step;
  } cfg_t;

  // per-transaction info carried from the update stage to the output stage
  typedef struct packed {
    outcome_e         outcome;
    logic [H_W-1:0]   raw;
    logic [CFG_W-1:0] jump_value;
  } res_ctl_t;

endpackage

/* hw/rtl/rlhs_in_if.sv */
// ----------------------------------------------------------------------------
// rlhs_in_if
// Input channel: one raw distance sample per transaction.
// ----------------------------------------------------------------------------
interface rlhs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance_mm;

  modport source (output valid, output distance_mm, input ready);
  modport sink (input valid, input distance_mm, output ready);
endinterface

/* hw/rtl/rlhs_out_if.sv */
// ----------------------------------------------------------------------------
// rlhs_out_if
// Output channel: one conditioned height per transaction.
// ----------------------------------------------------------------------------
interface rlhs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filtered_height;
  logic [15:0] raw_height_mm;
  logic [2:0]  outcome;

  modport source (output valid, output filtered_height, output raw_height_mm,
                  output outcome, input ready);
  modport sink (input valid, input filtered_height, input raw_height_mm,
                input outcome, output ready);
endinterface

/* hw/rtl/rlhs_cfg.sv */
// ----------------------------------------------------------------------------
// rlhs_cfg
// APB register file holding the seven threshold registers.
// ----------------------------------------------------------------------------
module rlhs_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rlhs_pkg::ADDR_W-1:0]  paddr,
  input  logic [rlhs_pkg::DATA_W-1:0]  pwdata,
  output logic [rlhs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output rlhs_pkg::cfg_t               cfg_o
);

  rlhs_pkg::cfg_t         cfg_q;
  logic [2:0]             idx;
  logic                   wr_en;
  logic [rlhs_pkg::CFG_W-1:0] wval;
  logic [rlhs_pkg::CFG_W-1:0] rval;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign wval   = pwdata[rlhs_pkg::CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_height  <= rlhs_pkg::RST_MAX_HEIGHT;
      cfg_q.fall_limit  <= rlhs_pkg::RST_FALL_LIMIT;
      cfg_q.rise_limit  <= rlhs_pkg::RST_RISE_LIMIT;
      cfg_q.jump_limit  <= rlhs_pkg::RST_JUMP_LIMIT;
      cfg_q.jump_value  <= rlhs_pkg::RST_JUMP_VALUE;
      cfg_q.blend_floor <= rlhs_pkg::RST_BLEND_FLOOR;
      cfg_q.blend_step  <= rlhs_pkg::RST_BLEND_STEP;
    end else if (wr_en) begin
      unique case (idx)
        rlhs_pkg::REG_MAX_HEIGHT:  cfg_q.max_height  <= wval;
        rlhs_pkg::REG_FALL_LIMIT:  cfg_q.fall_limit  <= wval;
        rlhs_pkg::REG_RISE_LIMIT:  cfg_q.rise_limit  <= wval;
        rlhs_pkg::REG_JUMP_LIMIT:  cfg_q.jump_limit  <= wval;
        rlhs_pkg::REG_JUMP_VALUE:  cfg_q.jump_value  <= wval;
        rlhs_pkg::REG_BLEND_FLOOR: cfg_q.blend_floor <= wval;
        rlhs_pkg::REG_BLEND_STEP:  cfg_q.blend_step  <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rlhs_pkg::REG_MAX_HEIGHT:  rval = cfg_q.max_height;
      rlhs_pkg::REG_FALL_LIMIT:  rval = cfg_q.fall_limit;
      rlhs_pkg::REG_RISE_LIMIT:  rval = cfg_q.rise_limit;
      rlhs_pkg::REG_JUMP_LIMIT:  rval = cfg_q.jump_limit;
      rlhs_pkg::REG_JUMP_VALUE:  rval = cfg_q.jump_value;
      rlhs_pkg::REG_BLEND_FLOOR: rval = cfg_q.blend_floor;
      rlhs_pkg::REG_BLEND_STEP:  rval = cfg_q.blend_step;
      default:                   rval = '0;
    endcase
  end

  assign prdata = rlhs_pkg::DATA_W'(rval);
  assign cfg_o  = cfg_q;

endmodule

/* hw/rtl/rlhs_core.sv */
// ----------------------------------------------------------------------------
// rlhs_core
// Sample checks, blending and window state update; keeps a running window
// sum so the limit checks against the window mean need no divider.
// ----------------------------------------------------------------------------
module rlhs_core #(
  parameter int unsigned WINDOW_LEN = 5,
  localparam int unsigned SUM_W     = rlhs_pkg::H_W + $clog2(WINDOW_LEN)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlhs_pkg::cfg_t     cfg_i,
  rlhs_in_if.sink            in_i,
  output logic               s1_valid_o,
  input  logic               s1_ready_i,
  output rlhs_pkg::res_ctl_t s1_ctl_o,
  output logic [SUM_W-1:0]   s1_sum_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
  localparam int unsigned N_W    = $clog2(WINDOW_LEN + 1);
  localparam int unsigned CMP_W  = rlhs_pkg::H_W + 1 + N_W;
  localparam int unsigned H_W    = rlhs_pkg::H_W;
  localparam int unsigned FB     = rlhs_pkg::FRAC_BITS;

  logic [H_W-1:0]    win_q [WINDOW_LEN];
  logic [SLOT_W-1:0] slot_q;
  logic [SUM_W-1:0]  sum_q;
  logic [H_W-1:0]    acc_q;

  logic                   s1_valid_q;
  rlhs_pkg::res_ctl_t     s1_ctl_q;
  logic [SUM_W-1:0]       s1_sum_q;

  logic [H_W-1:0]   raw, h_q;
  logic [H_W-1:0]   fall_lim, rise_lim, jump_lim, step_lim;
  logic [H_W:0]     fall_bound;
  logic [CMP_W-1:0] sum_ext, fall_prod, rise_prod, jump_prod;
  logic             fall_hit, rise_hit, jump_hit;
  logic [H_W:0]     diff;
  logic             blend_on;
  logic [32:0]      blend_prod;
  logic [H_W-1:0]   blended, sample;
  logic [SUM_W-1:0] sum_next;
  logic [SLOT_W-1:0] slot_next;
  rlhs_pkg::outcome_e outcome;
  logic             accept, ok;

  assign raw      = in_i.distance_mm;
  // only meaningful when raw is within range, i.e. below 4096
  assign h_q      = {raw[rlhs_pkg::CFG_W-1:0], {FB{1'b0}}};
  assign fall_lim = {cfg_i.fall_limit, {FB{1'b0}}};
  assign rise_lim = {cfg_i.rise_limit, {FB{1'b0}}};
  assign jump_lim = {cfg_i.jump_limit, {FB{1'b0}}};
  assign step_lim = {cfg_i.blend_step, {FB{1'b0}}};
  assign sum_ext  = CMP_W'(sum_q);

  // mean - h > F  <=>  sum >= N * (h + F + 1)
  assign fall_bound = (H_W+1)'(h_q) + (H_W+1)'(fall_lim) + (H_W+1)'(1);
  assign fall_prod  = CMP_W'(fall_bound) * CMP_W'(WINDOW_LEN);
  assign fall_hit   = sum_ext >= fall_prod;

  // h - mean > R  <=>  h > R and sum < N * (h - R)
  assign rise_prod = CMP_W'(H_W'(h_q - rise_lim)) * CMP_W'(WINDOW_LEN);
  assign rise_hit  = (h_q > rise_lim) && (sum_ext < rise_prod);
  assign jump_prod = CMP_W'(H_W'(h_q - jump_lim)) * CMP_W'(WINDOW_LEN);
  assign jump_hit  = (h_q > jump_lim) && (sum_ext < jump_prod);

  // (h + 19*acc) / 20 == acc + (h - acc) / 20 when h > acc
  assign diff       = {1'b0, h_q} - {1'b0, acc_q};
  assign blend_on   = (raw > H_W'(cfg_i.blend_floor)) && !diff[H_W] &&
                      (diff[H_W-1:0] > step_lim);
  assign blend_prod = 33'(diff[H_W-1:0]) * 33'(rlhs_pkg::DIV20_MUL);
  assign blended    = acc_q + H_W'(blend_prod[32:rlhs_pkg::DIV20_SHIFT]);
  assign sample     = blend_on ? blended : h_q;

  always_comb begin
    priority if (raw > H_W'(cfg_i.max_height)) begin
      outcome = rlhs_pkg::OUT_RANGE;
    end else if (fall_hit) begin
      outcome = rlhs_pkg::OUT_FALL;
    end else if (rise_hit) begin
      outcome = jump_hit ? rlhs_pkg::OUT_JUMP : rlhs_pkg::OUT_RISE;
    end else begin
      outcome = rlhs_pkg::OUT_OK;
    end
  end

  assign sum_next  = SUM_W'((SUM_W+1)'(sum_q) - (SUM_W+1)'(win_q[slot_q]) +
                            (SUM_W+1)'(sample));
  assign slot_next = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + SLOT_W'(1);

  assign in_i.ready = !s1_valid_q || s1_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign ok         = (outcome == rlhs_pkg::OUT_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) win_q[i] <= '0;
      slot_q     <= '0;
      sum_q      <= '0;
      acc_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (accept && ok) begin
        win_q[slot_q] <= sample;
        slot_q        <= slot_next;
        sum_q         <= sum_next;
        acc_q         <= sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q.outcome    <= outcome;
      s1_ctl_q.raw        <= raw;
      s1_ctl_q.jump_value <= cfg_i.jump_value;
      s1_sum_q            <= ok ? sum_next : sum_q;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_ctl_o   = s1_ctl_q;
  assign s1_sum_o   = s1_sum_q;

endmodule

/* hw/rtl/rlhs_mean.sv */
// ----------------------------------------------------------------------------
// rlhs_mean
// Output stage: window mean by reciprocal multiply (jump value on a jump), result register.
// ----------------------------------------------------------------------------
module rlhs_mean #(
  parameter int unsigned WINDOW_LEN = 5,
  localparam int unsigned SUM_W     = rlhs_pkg::H_W + $clog2(WINDOW_LEN)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_valid_i,
  output logic               s1_ready_o,
  input  rlhs_pkg::res_ctl_t s1_ctl_i,
  input  logic [SUM_W-1:0]   s1_sum_i,
  rlhs_out_if.source         out_o
);

  localparam int unsigned H_W   = rlhs_pkg::H_W;
  localparam int unsigned SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int unsigned M_W   = SUM_W + 1;
  localparam int unsigned P_W   = SUM_W + M_W;
  // ceil(2^SHIFT / N); error times any sum stays below 2^SHIFT, so exact floor
  localparam longint unsigned RECIP =
    ((longint'(1) << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;

  logic [P_W-1:0]     prod;
  logic [H_W-1:0]     mean;
  logic [H_W-1:0]     filt;
  logic               out_valid_q;
  logic [H_W-1:0]     filt_q;
  logic [H_W-1:0]     raw_q;
  rlhs_pkg::outcome_e outcome_q;

  assign prod = P_W'(s1_sum_i) * P_W'(M_W'(RECIP));
  assign mean = prod[SHIFT +: H_W];
  assign filt = (s1_ctl_i.outcome == rlhs_pkg::OUT_JUMP) ?
                {s1_ctl_i.jump_value, {rlhs_pkg::FRAC_BITS{1'b0}}} : mean;

  assign s1_ready_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) begin
      filt_q    <= filt;
      raw_q     <= s1_ctl_i.raw;
      outcome_q <= s1_ctl_i.outcome;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_height = filt_q;
  assign out_o.raw_height_mm   = raw_q;
  assign out_o.outcome         = outcome_q;

endmodule

/* hw/rtl/rate_limited_height_smoother_unit.sv */
// ----------------------------------------------------------------------------
// rate_limited_height_smoother_unit
// Range/rate checks, 1:19 blending and a moving average over an ultrasonic
// distance stream.
// Results pass the core's stage-1 register and then the output register.
// Throughput: one transaction per cycle while the receiver keeps ready high;
// the running window sum keeps the per-sample state loop free of a divider.
// Reset: registers return to their default thresholds, window, sum and
// last sample clear to zero; no clearing pass.
// ----------------------------------------------------------------------------
module rate_limited_height_smoother_unit #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rlhs_in_if.sink                     in_i,
  rlhs_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlhs_pkg::ADDR_W-1:0] paddr,
  input  logic [rlhs_pkg::DATA_W-1:0] pwdata,
  output logic [rlhs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned SUM_W = rlhs_pkg::H_W + $clog2(WINDOW_LEN);

  rlhs_pkg::cfg_t     cfg;
  logic               s1_valid;
  logic               s1_ready;
  rlhs_pkg::res_ctl_t s1_ctl;
  logic [SUM_W-1:0]   s1_sum;

  rlhs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rlhs_core #(.WINDOW_LEN(WINDOW_LEN)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_i       (in_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_ctl_o   (s1_ctl),
    .s1_sum_o   (s1_sum)
  );

  rlhs_mean #(.WINDOW_LEN(WINDOW_LEN)) u_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_ctl_i   (s1_ctl),
    .s1_sum_i   (s1_sum),
    .out_o      (out_o)
  );

endmodule

/* verif/tb_rate_limited_height_smoother_unit.sv */
// ----------------------------------------------------------------------------
// tb_rate_limited_height_smoother_unit
// Self-checking testbench of the height smoother. Each accepted distance is
// run through an in-bench predictor of the range, fall, rise and jump checks,
// the blending step and the window mean. Every result is compared field by
// field with the oldest predicted one. Traffic uses random bursts, receiver
// stalls and a long back-pressure hold, across several threshold settings.
// ----------------------------------------------------------------------------
module tb_rate_limited_height_smoother_unit;

  localparam int unsigned WINDOW_LEN  = 5;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam logic [2:0]  REG_NONE    = 3'd7;

  typedef struct packed {
    logic [rlhs_pkg::H_W-1:0] filtered_height;
    logic [rlhs_pkg::H_W-1:0] raw_height_mm;
    rlhs_pkg::outcome_e       outcome;
  } height_result_t;

  logic clk_i;
  logic rst_ni;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rlhs_pkg::ADDR_W-1:0] paddr;
  logic [rlhs_pkg::DATA_W-1:0] pwdata;
  logic [rlhs_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  rlhs_in_if  in_if ();
  rlhs_out_if out_if ();

  rate_limited_height_smoother_unit #(
    .WINDOW_LEN(WINDOW_LEN)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor state
  rlhs_pkg::cfg_t           thresholds;
  logic [rlhs_pkg::H_W-1:0] height_window [WINDOW_LEN];
  int unsigned              window_slot;
  logic [rlhs_pkg::H_W-1:0] prev_output;
  logic [rlhs_pkg::H_W-1:0] last_accepted;

  height_result_t pending_heights [$];
  int unsigned    mismatch_count;
  int unsigned    cycle_count;

  // receiver stall control
  int unsigned rx_max_stall;
  int unsigned rx_hold_len;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  function automatic rlhs_pkg::cfg_t default_thresholds();
    rlhs_pkg::cfg_t c;
    c.max_height  = rlhs_pkg::RST_MAX_HEIGHT;
    c.fall_limit  = rlhs_pkg::RST_FALL_LIMIT;
    c.rise_limit  = rlhs_pkg::RST_RISE_LIMIT;
    c.jump_limit  = rlhs_pkg::RST_JUMP_LIMIT;
    c.jump_value  = rlhs_pkg::RST_JUMP_VALUE;
    c.blend_floor = rlhs_pkg::RST_BLEND_FLOOR;
    c.blend_step  = rlhs_pkg::RST_BLEND_STEP;
    return c;
  endfunction

  function automatic rlhs_pkg::cfg_t random_thresholds();
    rlhs_pkg::cfg_t c;
    logic [95:0]    bits;
    if ($urandom_range(3) == 0) begin
      bits = {$urandom, $urandom, $urandom};
      c    = bits[$bits(rlhs_pkg::cfg_t)-1:0];
    end else begin
      c.max_height  = rlhs_pkg::CFG_W'($urandom_range(1500, 4095));
      c.fall_limit  = rlhs_pkg::CFG_W'($urandom_range(0, 1000));
      c.rise_limit  = rlhs_pkg::CFG_W'($urandom_range(0, 1000));
      c.jump_limit  = rlhs_pkg::CFG_W'($urandom_range(0, 1500));
      c.jump_value  = rlhs_pkg::CFG_W'($urandom);
      c.blend_floor = rlhs_pkg::CFG_W'($urandom_range(0, 3000));
      c.blend_step  = rlhs_pkg::CFG_W'($urandom_range(0, 200));
    end
    return c;
  endfunction

  // Q12.4 height conditioning; updates the predictor state on acceptance
  function automatic height_result_t smooth_height(input logic [rlhs_pkg::H_W-1:0] dist_mm);
    height_result_t res;
    int h_q;
    int last_q;
    int acc_q;
    int sum;
    h_q    = int'(dist_mm) * 16;
    last_q = int'(prev_output);
    acc_q  = int'(last_accepted);
    res.raw_height_mm   = dist_mm;
    res.filtered_height = prev_output;
    if (dist_mm > thresholds.max_height) begin
      res.outcome = rlhs_pkg::OUT_RANGE;
    end else if (last_q - h_q > int'(thresholds.fall_limit) * 16) begin
      res.outcome = rlhs_pkg::OUT_FALL;
    end else if (h_q - last_q > int'(thresholds.rise_limit) * 16) begin
      // jump only checked on a sample that already failed the rise test
      if (h_q - last_q > int'(thresholds.jump_limit) * 16) begin
        res.outcome         = rlhs_pkg::OUT_JUMP;
        res.filtered_height = {thresholds.jump_value, 4'b0000};
      end else begin
        res.outcome = rlhs_pkg::OUT_RISE;
      end
    end else begin
      if (dist_mm > thresholds.blend_floor &&
          h_q - acc_q > int'(thresholds.blend_step) * 16) begin
        h_q = (h_q + 19 * acc_q) / 20;
      end
      last_accepted = rlhs_pkg::H_W'(h_q);
      height_window[window_slot] = rlhs_pkg::H_W'(h_q);
      window_slot = (window_slot + 1 >= WINDOW_LEN) ? 0 : window_slot + 1;
      sum = 0;
      foreach (height_window[i]) sum += int'(height_window[i]);
      prev_output         = rlhs_pkg::H_W'(sum / WINDOW_LEN);
      res.filtered_height = prev_output;
      res.outcome         = rlhs_pkg::OUT_OK;
    end
    return res;
  endfunction

  // mostly samples near the current output, so the window keeps moving
  function automatic logic [rlhs_pkg::H_W-1:0] next_distance();
    int pick;
    int span;
    int d;
    pick = $urandom_range(99);
    if (pick < 60) begin
      span = $urandom_range(0, 700);
      d = int'(prev_output >> 4) + $urandom_range(0, 2 * span) - span;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      return rlhs_pkg::H_W'(d);
    end else if (pick < 80) begin
      return rlhs_pkg::H_W'($urandom_range(0, int'(thresholds.max_height) + 50));
    end else if (pick < 90) begin
      return rlhs_pkg::H_W'($urandom_range(0, 4095));
    end
    return rlhs_pkg::H_W'($urandom);
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_distance(input logic [rlhs_pkg::H_W-1:0] dist_mm);
    in_if.valid       <= 1'b1;
    in_if.distance_mm <= dist_mm;
    do @(posedge clk_i); while (!in_if.ready);
    pending_heights.push_back(smooth_height(dist_mm));
  endtask

  task automatic idle_cycles(input int unsigned n);
    in_if.valid       <= 1'b0;
    in_if.distance_mm <= rlhs_pkg::H_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_stream(input int unsigned n, input int unsigned max_gap);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 32);
      for (int unsigned k = 0; k < burst && sent < n; k++) begin
        send_distance(next_distance());
        sent++;
      end
      if (max_gap != 0 && $urandom_range(3) != 0) idle_cycles($urandom_range(1, max_gap));
    end
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending_heights.size() != 0 && waited < DRAIN_LIMIT);
    if (pending_heights.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d results never arrived", $time, pending_heights.size());
      pending_heights.delete();
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // write, then read back through the same port
  task automatic write_reg(input logic [2:0] idx, input logic [rlhs_pkg::CFG_W-1:0] value);
    logic [rlhs_pkg::DATA_W-1:0] junk;
    logic [rlhs_pkg::DATA_W-1:0] want;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[rlhs_pkg::DATA_W-1:rlhs_pkg::CFG_W], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    want = rlhs_pkg::DATA_W'(value);
    unique case (idx)
      rlhs_pkg::REG_MAX_HEIGHT:  thresholds.max_height  = value;
      rlhs_pkg::REG_FALL_LIMIT:  thresholds.fall_limit  = value;
      rlhs_pkg::REG_RISE_LIMIT:  thresholds.rise_limit  = value;
      rlhs_pkg::REG_JUMP_LIMIT:  thresholds.jump_limit  = value;
      rlhs_pkg::REG_JUMP_VALUE:  thresholds.jump_value  = value;
      rlhs_pkg::REG_BLEND_FLOOR: thresholds.blend_floor = value;
      rlhs_pkg::REG_BLEND_STEP:  thresholds.blend_step  = value;
      default:                   want = '0;
    endcase
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      mismatch_count++;
      $display("%0t: prdata at index %0d expected %h got %h", $time, idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_thresholds(input rlhs_pkg::cfg_t c);
    write_reg(rlhs_pkg::REG_MAX_HEIGHT, c.max_height);
    write_reg(rlhs_pkg::REG_FALL_LIMIT, c.fall_limit);
    write_reg(rlhs_pkg::REG_RISE_LIMIT, c.rise_limit);
    write_reg(rlhs_pkg::REG_JUMP_LIMIT, c.jump_limit);
    write_reg(rlhs_pkg::REG_JUMP_VALUE, c.jump_value);
    write_reg(rlhs_pkg::REG_BLEND_FLOOR, c.blend_floor);
    write_reg(rlhs_pkg::REG_BLEND_STEP, c.blend_step);
    // unmapped index must not disturb anything
    write_reg(REG_NONE, rlhs_pkg::CFG_W'($urandom));
  endtask

  // --------------------------------------------------------------- receiver

  initial begin : receiver
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
        if (rx_max_stall != 0) begin
          out_if.ready <= 1'b0;
          repeat ($urandom_range(1, rx_max_stall)) @(posedge clk_i);
        end
      end
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin : check_result
      height_result_t want;
      if (pending_heights.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result filtered=%h raw=%h outcome=%0d", $time,
                 out_if.filtered_height, out_if.raw_height_mm, out_if.outcome);
      end else begin
        want = pending_heights.pop_front();
        if (out_if.filtered_height !== want.filtered_height) begin
          mismatch_count++;
          $display("%0t: filtered_height expected %h got %h", $time,
                   want.filtered_height, out_if.filtered_height);
        end
        if (out_if.raw_height_mm !== want.raw_height_mm) begin
          mismatch_count++;
          $display("%0t: raw_height_mm expected %h got %h", $time,
                   want.raw_height_mm, out_if.raw_height_mm);
        end
        if (out_if.outcome !== want.outcome) begin
          mismatch_count++;
          $display("%0t: outcome expected %0d got %0d", $time, want.outcome, out_if.outcome);
        end
      end
    end
  end

  // ------------------------------------------------------------------ tests

  task automatic test_directed_corners();
    logic [rlhs_pkg::H_W-1:0] corner_list [24] = '{
      16'd0, 16'd400, 16'd401, 16'hFFFF, 16'd2501, 16'd2500, 16'd4095, 16'h8000,
      16'h5555, 16'hAAAA, 16'd300, 16'd600, 16'd601, 16'd700, 16'd800, 16'd900,
      16'd1000, 16'd1100, 16'd1200, 16'd0, 16'd1700, 16'd2400, 16'd1, 16'd2
    };
    rx_max_stall = 0;
    foreach (corner_list[i]) send_distance(corner_list[i]);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    rlhs_pkg::cfg_t c;
    // everything zero: only a zero distance can get through
    c = '0;
    write_thresholds(c);
    rx_max_stall = 4;
    send_distance(16'd0);
    send_distance(16'd1);
    send_stream(30, 3);
    wait_drained();
    // everything at full scale
    c = '1;
    write_thresholds(c);
    send_stream(30, 3);
    wait_drained();
    // jump limit below rise limit: every rise reject becomes a jump reject
    c = default_thresholds();
    c.rise_limit = 12'd500;
    c.jump_limit = 12'd200;
    write_thresholds(c);
    send_distance(16'd450);
    send_distance(16'd1000);
    send_distance(16'd2400);
    send_stream(30, 3);
    wait_drained();
    write_thresholds(default_thresholds());
  endtask

  task automatic test_backpressure();
    rx_max_stall = 0;
    rx_hold_len  = 300;
    send_stream(80, 0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned stall_opts [3] = '{0, 3, 12};
    int unsigned gap_opts [3]   = '{0, 4, 15};
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 0) write_thresholds(default_thresholds());
      else write_thresholds(random_thresholds());
      rx_max_stall = stall_opts[$urandom_range(2)];
      send_stream(500, gap_opts[$urandom_range(2)]);
      wait_drained();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.distance_mm = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mismatch_count    = 0;
    rx_max_stall      = 0;
    rx_hold_len       = 0;
    thresholds        = default_thresholds();
    foreach (height_window[i]) height_window[i] = '0;
    window_slot   = 0;
    prev_output   = '0;
    last_accepted = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
